>>> hw/rtl/fdcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcrc_pkg
// Shared constants and types for the length-prefixed frame decoder.
// ----------------------------------------------------------------------------
package fdcrc_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // frame geometry
  localparam int unsigned MAX_PAYLOAD    = 256;  // largest accepted length field
  localparam int unsigned HEADER_BYTES   = 5;    // start, length, number
  localparam int unsigned OVERHEAD_BYTES = 7;    // header plus CRC
  localparam int unsigned COUNT_W        = 9;    // saturating byte counter

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_SIZE      = 3'd4,
    ST_CRC       = 3'd5
  } status_t;

endpackage

>>> hw/rtl/fdcrc_crc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcrc_crc_step
// One-byte CRC-16/CCITT-FALSE update, MSB first, eight bits unrolled.
// ----------------------------------------------------------------------------
module fdcrc_crc_step
  import fdcrc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  logic [15:0] c;

  always_comb begin
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> hw/rtl/frame_decoder_crc16_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_decoder_crc16_check_unit
// Length-prefixed frame decoder with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per transfer, data_byte,
//   with last_byte set on the final byte of the buffered frame.
//   Output channel (out_valid/out_ready): one result per transfer. A payload
//   byte (result_kind 0) carries the byte and its index; the verdict
//   (result_kind 1) carries message number, length field and status.
//   Header, CRC and bad-start or too-long frame bytes give no result.
//   Config channel (cfg_valid/cfg_ready): writes start_byte; always ready.
//   Write it only while no frame is in progress.
// Timing:
//   One byte per cycle while the receiver keeps up. The result of a byte
//   is registered as it is taken. The single output register decouples
//   the sides: a new byte is taken while the held result leaves in the same
//   cycle; in_ready drops only while a result waits on a stalled receiver.
// Reset:
//   rst (synchronous) empties the output register, clears the frame state
//   and sets start_byte to zero. No clearing pass; ready the cycle after.
// ----------------------------------------------------------------------------
module frame_decoder_crc16_check_unit
  import fdcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  start_byte,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [15:0] message_number,
  output logic [15:0] payload_length,
  output logic [2:0]  status
);

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam logic [16:0] MAX_LEN   = 17'(MAX_PAYLOAD);
  localparam logic [16:0] HDR_LEN   = 17'(HEADER_BYTES);
  localparam logic [16:0] OVH_LEN   = 17'(OVERHEAD_BYTES);

  // configuration
  logic [7:0] start_cfg;

  // frame state
  logic [COUNT_W-1:0] byte_count;
  logic               start_seen_ok;
  logic [15:0]        length_field;
  logic [15:0]        number_field;
  logic [15:0]        running_crc;
  logic [15:0]        frame_crc;

  logic [COUNT_W-1:0] byte_count_next;
  logic               start_seen_ok_next;
  logic [15:0]        length_field_next;
  logic [15:0]        number_field_next;
  logic [15:0]        running_crc_next;
  logic [15:0]        frame_crc_next;

  // output register
  status_t status_reg;

  logic        in_xfer;
  logic        counting;
  logic [16:0] pos_w;
  logic [16:0] crc_end;
  logic        past_header;
  logic        in_body;
  logic        emit_payload;
  logic [15:0] crc_stepped;
  status_t     verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  fdcrc_crc_step u_crc (
    .crc_in  (running_crc),
    .data    (data_byte),
    .crc_out (crc_stepped)
  );

  // Position decode for the byte at hand. The saturated count freezes all
  // field capture, CRC and payload output.
  always_comb begin
    counting    = (byte_count != COUNT_SAT);
    pos_w       = 17'(byte_count);
    crc_end     = HDR_LEN + 17'(length_field);   // one past the payload
    past_header = (pos_w >= HDR_LEN);
    in_body     = counting && (byte_count != '0) && (pos_w < crc_end);
    emit_payload = counting && past_header && (pos_w < crc_end) &&
                   start_seen_ok && (17'(length_field) <= MAX_LEN);

    start_seen_ok_next = start_seen_ok;
    length_field_next  = length_field;
    number_field_next  = number_field;
    frame_crc_next     = frame_crc;
    running_crc_next   = in_body ? crc_stepped : running_crc;
    byte_count_next    = counting ? byte_count + 1'b1 : byte_count;

    if (counting) begin
      unique case (byte_count)
        COUNT_W'(0): start_seen_ok_next = (data_byte == start_cfg);
        COUNT_W'(1): length_field_next  = {length_field[15:8], data_byte};
        COUNT_W'(2): length_field_next  = {data_byte, length_field[7:0]};
        COUNT_W'(3): number_field_next  = {number_field[15:8], data_byte};
        COUNT_W'(4): number_field_next  = {data_byte, number_field[7:0]};
        default: begin
          if (pos_w == crc_end) begin
            frame_crc_next = {frame_crc[15:8], data_byte};
          end else if (pos_w == crc_end + 17'd1) begin
            frame_crc_next = {data_byte, frame_crc[7:0]};
          end
        end
      endcase
    end

    // Verdict. When the size matches, the closing byte is the CRC high byte,
    // which leaves the running CRC untouched, so the held value is final.
    priority if (17'(byte_count_next) < OVH_LEN) begin
      verdict = ST_SHORT;
    end else if (!start_seen_ok_next) begin
      verdict = ST_BAD_START;
    end else if (17'(length_field_next) > MAX_LEN) begin
      verdict = ST_TOO_LONG;
    end else if (17'(byte_count_next) != OVH_LEN + 17'(length_field_next)) begin
      verdict = ST_SIZE;
    end else if (running_crc != frame_crc_next) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_cfg <= start_byte;
    end
  end

  // frame state: updated per byte, cleared after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      start_seen_ok <= 1'b0;
      length_field  <= '0;
      number_field  <= '0;
      running_crc   <= CRC_INIT;
      frame_crc     <= '0;
    end else if (in_xfer) begin
      if (last_byte) begin
        byte_count    <= '0;
        start_seen_ok <= 1'b0;
        length_field  <= '0;
        number_field  <= '0;
        running_crc   <= CRC_INIT;
        frame_crc     <= '0;
      end else begin
        byte_count    <= byte_count_next;
        start_seen_ok <= start_seen_ok_next;
        length_field  <= length_field_next;
        number_field  <= number_field_next;
        running_crc   <= running_crc_next;
        frame_crc     <= frame_crc_next;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && (last_byte || emit_payload)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer && (last_byte || emit_payload)) begin
      message_number <= number_field_next;
      payload_length <= length_field_next;
      if (last_byte) begin
        result_kind   <= KIND_VERDICT;
        payload_byte  <= '0;
        payload_index <= '0;
        status_reg    <= verdict;
      end else begin
        result_kind   <= KIND_PAYLOAD;
        payload_byte  <= data_byte;
        payload_index <= 8'(byte_count - COUNT_W'(HEADER_BYTES));
        status_reg    <= ST_OK;
      end
    end
  end

  assign status = status_reg;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> byte_count == '0 && running_crc == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_count_moves : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_byte |=> byte_count != '0)
    else $error("byte count did not advance");

  a_payload_status : assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |-> status == ST_OK)
    else $error("payload result carries a status");

  a_no_drop : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready ##1
      (out_valid && $stable(payload_byte) && $stable(status)))
    else $error("stalled result lost or input taken over it");

endmodule

>>> bench/frame_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the config, byte and result channels of the frame decoder, keeps
// its own copy of the frame state, predicts every result and compares it.
// ----------------------------------------------------------------------------
module frame_result_checker
  import fdcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  start_byte,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [7:0]  payload_byte,
  input  logic [7:0]  payload_index,
  input  logic [15:0] message_number,
  input  logic [15:0] payload_length,
  input  logic [2:0]  status,
  output int          error_count,
  output int          results_pending
);

  localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pl_byte;
    logic [7:0]  pl_index;
    logic [15:0] number;
    logic [15:0] length;
    status_t     st;
  } frame_result_t;

  frame_result_t expected_results[$];

  // mirrored decoder state
  logic [7:0]  cfg_start;
  logic [8:0]  frame_pos;
  logic        start_ok;
  logic [15:0] len_fld;
  logic [15:0] num_fld;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  int          fail_total;
  int          results_seen;

  assign error_count = fail_total;

  initial begin
    fail_total   = 0;
    results_seen = 0;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    int          b;
    c = crc ^ {d, 8'h00};
    for (b = 0; b < 8; b++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  task automatic clear_frame_state();
    frame_pos = '0;
    start_ok  = 1'b0;
    len_fld   = '0;
    num_fld   = '0;
    crc_acc   = CRC_INIT;
    crc_rx    = '0;
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic is_last);
    int unsigned   pos;
    int unsigned   pay_end;
    logic          emit;
    frame_result_t r;
    pos     = 32'(frame_pos);
    pay_end = HEADER_BYTES + 32'(len_fld);
    emit    = 1'b0;
    // a saturated count freezes everything but the verdict
    if (pos < COUNT_LIMIT) begin
      if (pos == 0)                start_ok = (d == cfg_start);
      else if (pos == 1)           len_fld[7:0] = d;
      else if (pos == 2)           len_fld[15:8] = d;
      else if (pos == 3)           num_fld[7:0] = d;
      else if (pos == 4)           num_fld[15:8] = d;
      else if (pos < pay_end)      emit = start_ok && (len_fld <= MAX_PAYLOAD);
      else if (pos == pay_end)     crc_rx[7:0] = d;
      else if (pos == pay_end + 1) crc_rx[15:8] = d;
      if (pos >= 1 && pos < pay_end) crc_acc = crc_step(crc_acc, d);
      frame_pos = 9'(pos + 1);
    end
    r.number = num_fld;
    r.length = len_fld;
    if (!is_last) begin
      if (emit) begin
        r.kind     = KIND_PAYLOAD;
        r.pl_byte  = d;
        r.pl_index = 8'(pos - HEADER_BYTES);
        r.st       = ST_OK;
        expected_results.push_back(r);
      end
    end else begin
      r.kind     = KIND_VERDICT;
      r.pl_byte  = 8'h00;
      r.pl_index = 8'h00;
      if (frame_pos < OVERHEAD_BYTES)                 r.st = ST_SHORT;
      else if (!start_ok)                             r.st = ST_BAD_START;
      else if (len_fld > MAX_PAYLOAD)                 r.st = ST_TOO_LONG;
      else if (frame_pos != OVERHEAD_BYTES + len_fld) r.st = ST_SIZE;
      else if (crc_acc != crc_rx)                     r.st = ST_CRC;
      else                                            r.st = ST_OK;
      expected_results.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    frame_result_t got;
    got.kind     = result_kind;
    got.pl_byte  = payload_byte;
    got.pl_index = payload_index;
    got.number   = message_number;
    got.length   = payload_length;
    got.st       = status_t'(status);
    results_seen++;
    if (expected_results.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: result %0d arrived with nothing pending: %s",
                 $time, results_seen,
                 $sformatf("kind=%0d byte=%02h idx=%0d num=%04h len=%04h st=%0d",
                           got.kind, got.pl_byte, got.pl_index, got.number,
                           got.length, got.st));
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.pl_byte !== want.pl_byte ||
          got.pl_index !== want.pl_index || got.number !== want.number ||
          got.length !== want.length || got.st !== want.st) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("%0t: result %0d differs", $time, results_seen);
          $display("  want kind=%0d byte=%02h idx=%0d num=%04h len=%04h st=%0d",
                   want.kind, want.pl_byte, want.pl_index, want.number, want.length, want.st);
          $display("  got  kind=%0d byte=%02h idx=%0d num=%04h len=%04h st=%0d",
                   got.kind, got.pl_byte, got.pl_index, got.number, got.length, got.st);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame_state();
      cfg_start = 8'h00;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) cfg_start = start_byte;
      if (in_valid && in_ready)   decode_byte(data_byte, last_byte);
      if (out_valid && out_ready) check_result();
    end
    results_pending <= expected_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the frame decoder: a few hand-built frames, then phases of
// random frames (mostly well formed, some corrupted, truncated, padded or
// pure noise) under several start byte settings, with random idling on both
// channels. Prediction and comparison live in frame_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import fdcrc_pkg::*;

  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 280;   // bytes sent per phase
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;     // settle margin once no result is pending

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  start_byte;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [15:0] message_number;
  logic [15:0] payload_length;
  logic [2:0]  status;
  int          error_count;
  int          results_pending;

  // idling controls shared between the stimulus and the result sink
  bit          tx_gap_en;
  bit          rx_stall_en;
  bit          hold_req;
  int unsigned bytes_sent;

  // frame under construction, sent byte by byte
  logic [7:0]  frame_bytes[$];

  always #5 clk = ~clk;

  frame_decoder_crc16_check_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_byte     (start_byte),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .message_number (message_number),
    .payload_length (payload_length),
    .status         (status)
  );

  frame_result_checker u_frame_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .start_byte      (start_byte),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .payload_byte    (payload_byte),
    .payload_index   (payload_index),
    .message_number  (message_number),
    .payload_length  (payload_length),
    .status          (status),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // CRC-16/CCITT-FALSE over one byte, used only to seal outgoing frames
  function automatic logic [15:0] crc_encode(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    int          b;
    c = crc ^ {d, 8'h00};
    for (b = 0; b < 8; b++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // payload bytes lean toward the extremes now and then
  function automatic logic [7:0] rand_byte();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed frame: start, length, number, payload, CRC (all LE)
  task automatic build_frame(input logic [7:0] sb, input logic [15:0] len,
                             input logic [15:0] num);
    logic [15:0] c;
    int          i;
    frame_bytes.delete();
    frame_bytes.push_back(sb);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(num[7:0]);
    frame_bytes.push_back(num[15:8]);
    repeat (len) frame_bytes.push_back(rand_byte());
    c = CRC_INIT;
    for (i = 1; i < frame_bytes.size(); i++) c = crc_encode(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  // One byte transfer. Valid stays up across back-to-back bytes; a random
  // gap may follow the transfer.
  task automatic send_byte(input logic [7:0] d, input logic is_last);
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (tx_gap_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid and wait until every predicted result has left the decoder.
  // An opening wait lets the checker count the last transfer.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // start byte is only rewritten with the decoder idle
  task automatic write_start(input logic [7:0] v);
    wait_idle();
    cfg_valid  <= 1'b1;
    start_byte <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
  endtask

  // One random frame. Mostly intact frames with small payloads; the rest
  // hits every verdict: CRC error, bad start, oversize length, truncation
  // (incl. last byte inside the payload), trailing junk and raw noise.
  task automatic random_frame(input logic [7:0] sb);
    int unsigned sel;
    int unsigned idx;
    logic [15:0] len;
    logic [15:0] big;
    sel = $urandom_range(0, 99);
    len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(25, MAX_PAYLOAD))
                                       : 16'($urandom_range(0, 12));
    build_frame(sb, len, 16'($urandom_range(0, 65535)));
    if (sel < 58) begin
      // intact
    end else if (sel < 66) begin
      idx = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end else if (sel < 72) begin
      frame_bytes[0] = sb ^ 8'($urandom_range(1, 255));
    end else if (sel < 78) begin
      case ($urandom_range(0, 3))
        0:       big = 16'(MAX_PAYLOAD + 1);
        1:       big = 16'hFFFF;
        default: big = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
      endcase
      build_frame(sb, 16'd0, 16'($urandom_range(0, 65535)));
      frame_bytes[1] = big[7:0];
      frame_bytes[2] = big[15:8];
      repeat ($urandom_range(0, 4)) frame_bytes.push_back(rand_byte());
    end else if (sel < 86) begin
      repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
    end else if (sel < 92) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(rand_byte());
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(rand_byte());
    end
  endtask

  // Result sink: random stall bursts, plus one long hold-off on request so
  // the single output register fills and in_ready drops.
  initial begin : result_sink
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [7:0]  sb;
    int unsigned phase_start;
    int          p;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    start_byte <= 8'h00;
    in_valid   <= 1'b0;
    data_byte  <= 8'h00;
    last_byte  <= 1'b0;
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed frames, start byte at its reset value of zero ---
    sb = 8'h00;
    // minimal good frame: empty payload, number all ones
    build_frame(sb, 16'd0, 16'hFFFF);
    send_frame();
    // two-byte buffer: short, partial length field reported
    frame_bytes = {8'hFF, 8'h00};
    send_frame();
    // wrong start byte on an otherwise sound frame
    build_frame(sb, 16'd0, 16'h0001);
    frame_bytes[0] = 8'h5A;
    send_frame();
    // length far over the limit, 7 bytes so the short check passes
    frame_bytes = {sb, 8'hFF, 8'hFF, 8'h34, 8'h12, 8'h00, 8'h00};
    send_frame();
    // buffer ends inside the payload: verdict replaces the payload byte
    build_frame(sb, 16'd5, 16'h8000);
    while (frame_bytes.size() > 7) void'(frame_bytes.pop_back());
    send_frame();

    // --- random phases, each under its own start byte ---
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       sb = 8'hFF;
        1:       sb = 8'h00;
        default: sb = 8'($urandom_range(1, 254));
      endcase
      write_start(sb);
      phase_start = bytes_sent;
      if (p == 1) begin
        // largest legal payload, indexes run 0..255
        build_frame(sb, 16'(MAX_PAYLOAD), 16'($urandom_range(0, 65535)));
        send_frame();
      end
      if (p == 2) begin
        // count saturates: well past 511 bytes, frame ends in size error
        build_frame(sb, 16'd40, 16'($urandom_range(0, 65535)));
        while (frame_bytes.size() < 530) frame_bytes.push_back(rand_byte());
        send_frame();
        // long hold-off on the receiver while bytes keep coming
        tx_gap_en = 1'b0;
        hold_req  = 1'b1;
        build_frame(sb, 16'd30, 16'($urandom_range(0, 65535)));
        send_frame();
      end
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        // idling toggles per frame; the last phase runs flat out
        tx_gap_en   = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        rx_stall_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_frame(sb);
        send_frame();
        // sometimes stop and let every result drain before going on
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
    end

    wait_idle();
    if (error_count == 0 && results_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fdcrc_pkg.sv
hw/rtl/fdcrc_crc_step.sv
hw/rtl/frame_decoder_crc16_check_unit.sv
bench/frame_result_checker.sv
bench/tb_top.sv
